[design/glp_pkg.sv]
// Shared types, codes and character decode for the gate-list text parser.
package glp_pkg;

    // Largest wire index width; wider word values raise an overflow result.
    localparam int INDEX_WIDTH = 16;

    localparam int CHAR_W  = 8;
    localparam int SYM_W   = 7;
    localparam int TILDE_W = 10;
    localparam int WIRE_W  = 16;
    localparam int KIND_W  = 3;
    localparam int CLS_W   = 3;
    localparam int WCNT_W  = 3;
    // 82 + 83 * 1023 fits in 17 bits
    localparam int VAL_W   = 17;

    localparam logic [SYM_W-1:0]   ALPHA_BASE = 7'd83;
    localparam logic [TILDE_W-1:0] TILDE_MAX  = 10'd1023;
    localparam logic [32:0]        INDEX_LIMIT = 33'd1 << INDEX_WIDTH;
    localparam logic [SYM_W-1:0]   HASH_SYM   = 7'd64;

    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Character classes handed from the front to the back
    localparam logic [CLS_W-1:0] CLS_SYM     = 3'd0;
    localparam logic [CLS_W-1:0] CLS_TILDE   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_SEMI    = 3'd2;
    localparam logic [CLS_W-1:0] CLS_BLANK   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_NEWLINE = 3'd4;
    localparam logic [CLS_W-1:0] CLS_HASH    = 3'd5;
    localparam logic [CLS_W-1:0] CLS_BAD     = 3'd6;
    localparam logic [CLS_W-1:0] CLS_END     = 3'd7;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_GATE         = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BAD_COUNT    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_CHAR     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNTERMINATED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END_OK       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW     = 3'd5;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [SYM_W-1:0] sym;
    } item_t;

    // Position in the 83-symbol alphabet; ok is low for a non-symbol.
    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] sym;
    } sym_lookup_t;

    function automatic sym_lookup_t symbol_of(input logic [CHAR_W-1:0] ch);
        sym_lookup_t r;
        r.ok  = 1'b1;
        r.sym = '0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            r.sym = SYM_W'(ch - 8'h30);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            r.sym = SYM_W'(ch - 8'h61 + 8'd10);
        end
        else if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            r.sym = SYM_W'(ch - 8'h41 + 8'd36);
        end
        else
        begin
            unique case (ch)
                8'h21:   r.sym = 7'd62; // !
                8'h40:   r.sym = 7'd63; // @
                8'h23:   r.sym = 7'd64; // #
                8'h24:   r.sym = 7'd65; // $
                8'h25:   r.sym = 7'd66; // %
                8'h5E:   r.sym = 7'd67; // ^
                8'h26:   r.sym = 7'd68; // &
                8'h2A:   r.sym = 7'd69; // *
                8'h28:   r.sym = 7'd70; // (
                8'h29:   r.sym = 7'd71; // )
                8'h2D:   r.sym = 7'd72; // -
                8'h5F:   r.sym = 7'd73; // _
                8'h3D:   r.sym = 7'd74; // =
                8'h2B:   r.sym = 7'd75; // +
                8'h5B:   r.sym = 7'd76; // [
                8'h5D:   r.sym = 7'd77; // ]
                8'h7B:   r.sym = 7'd78; // {
                8'h7D:   r.sym = 7'd79; // }
                8'h3C:   r.sym = 7'd80; // <
                8'h3E:   r.sym = 7'd81; // >
                8'h3F:   r.sym = 7'd82; // ?
                default: r.ok  = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

[design/glp_front.sv]
// Front stage: accepts characters, classifies them and pushes them to the queue.
module glp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [glp_pkg::CHAR_W-1:0] in_char,
    input  logic                       in_end,
    output logic                       push_valid,
    input  logic                       push_ready,
    output glp_pkg::item_t             push_item
);
    import glp_pkg::*;

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    sym_lookup_t lk;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        lk             = symbol_of(in_char);
        item_next.sym  = lk.sym;
        if (in_end)
            item_next.cls = CLS_END;
        else if (in_char == CH_SEMI)
            item_next.cls = CLS_SEMI;
        else if (in_char == CH_TILDE)
            item_next.cls = CLS_TILDE;
        else if (in_char == CH_LF || in_char == CH_CR)
            item_next.cls = CLS_NEWLINE;
        else if (in_char == CH_TAB || in_char == CH_SPACE)
            item_next.cls = CLS_BLANK;
        else if (in_char == CH_HASH)
            item_next.cls = CLS_HASH;
        else if (lk.ok)
            item_next.cls = CLS_SYM;
        else
            item_next.cls = CLS_BAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

endmodule

[design/glp_queue.sv]
// Two-entry queue between the front and back stages.
module glp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  glp_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output glp_pkg::item_t pop_item
);
    import glp_pkg::*;

    item_t       mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

[design/glp_back.sv]
// Back stage: parser state, word assembly and the result register.
module glp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  glp_pkg::item_t             pop_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [glp_pkg::KIND_W-1:0] out_kind,
    output logic [glp_pkg::WIRE_W-1:0] out_target,
    output logic [glp_pkg::WIRE_W-1:0] out_ctl_one,
    output logic [glp_pkg::WIRE_W-1:0] out_ctl_two
);
    import glp_pkg::*;

    logic                in_comment_reg, in_comment_next;
    logic                line_start_reg, line_start_next;
    logic [TILDE_W-1:0]  tilde_reg, tilde_next;
    logic [WCNT_W-1:0]   wcnt_reg, wcnt_next;
    logic                halted_reg, halted_next;
    logic [WIRE_W-1:0]   words [3];

    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [WIRE_W-1:0]   target_reg, ctl_one_reg, ctl_two_reg;

    logic                pop;
    logic                emit;
    logic                store_word;
    logic                is_gate;
    logic [VAL_W-1:0]    value;
    logic                overflow;

    assign pop_ready   = !out_valid_reg || out_ready;
    assign pop         = pop_valid && pop_ready;
    assign out_valid   = out_valid_reg;
    assign out_kind    = kind_reg;
    assign out_target  = target_reg;
    assign out_ctl_one = ctl_one_reg;
    assign out_ctl_two = ctl_two_reg;

    assign value    = VAL_W'(pop_item.sym) + VAL_W'(tilde_reg) * VAL_W'(ALPHA_BASE);
    assign overflow = 33'(value) >= INDEX_LIMIT;

    always_comb
    begin
        in_comment_next = in_comment_reg;
        line_start_next = line_start_reg;
        tilde_next      = tilde_reg;
        wcnt_next       = wcnt_reg;
        halted_next     = halted_reg;
        kind_next       = KIND_GATE;
        emit            = 1'b0;
        store_word      = 1'b0;
        is_gate         = 1'b0;
        if (pop_item.cls == CLS_END)
        begin
            emit            = !halted_reg;
            kind_next       = (wcnt_reg != '0) ? KIND_UNTERMINATED : KIND_END_OK;
            in_comment_next = 1'b0;
            line_start_next = 1'b1;
            tilde_next      = '0;
            wcnt_next       = '0;
            halted_next     = 1'b0;
        end
        else if (halted_reg)
        begin
            // frozen until end of text
        end
        else if (in_comment_reg)
        begin
            if (pop_item.cls == CLS_NEWLINE)
            begin
                in_comment_next = 1'b0;
                line_start_next = 1'b1;
            end
        end
        else if (pop_item.cls == CLS_HASH && line_start_reg)
        begin
            in_comment_next = 1'b1;
        end
        else
        begin
            unique case (pop_item.cls)
                CLS_SEMI:
                begin
                    tilde_next = '0;
                    if (wcnt_reg == 3'd3)
                    begin
                        emit      = 1'b1;
                        is_gate   = 1'b1;
                        kind_next = KIND_GATE;
                        wcnt_next = '0;
                    end
                    else if (wcnt_reg != '0)
                    begin
                        emit        = 1'b1;
                        kind_next   = KIND_BAD_COUNT;
                        halted_next = 1'b1;
                    end
                end
                CLS_TILDE:
                begin
                    line_start_next = 1'b0;
                    if (tilde_reg == TILDE_MAX)
                    begin
                        emit        = 1'b1;
                        kind_next   = KIND_OVERFLOW;
                        halted_next = 1'b1;
                    end
                    else
                        tilde_next = tilde_reg + 1'b1;
                end
                CLS_NEWLINE:
                    line_start_next = 1'b1;
                CLS_BLANK:
                begin
                end
                CLS_BAD:
                begin
                    emit        = 1'b1;
                    kind_next   = KIND_BAD_CHAR;
                    halted_next = 1'b1;
                end
                default: // symbol, or '#' away from line start
                begin
                    if (overflow)
                    begin
                        emit        = 1'b1;
                        kind_next   = KIND_OVERFLOW;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        store_word      = (wcnt_reg < 3'd3);
                        if (wcnt_reg < 3'd4)
                            wcnt_next = wcnt_reg + 1'b1;
                        tilde_next      = '0;
                        line_start_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_comment_reg <= 1'b0;
            line_start_reg <= 1'b1;
            tilde_reg      <= '0;
            wcnt_reg       <= '0;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                in_comment_reg <= in_comment_next;
                line_start_reg <= line_start_next;
                tilde_reg      <= tilde_next;
                wcnt_reg       <= wcnt_next;
                halted_reg     <= halted_next;
            end
            if (pop_ready)
                out_valid_reg <= pop && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && store_word)
            words[wcnt_reg[1:0]] <= value[WIRE_W-1:0];
        if (pop && emit)
        begin
            kind_reg    <= kind_next;
            target_reg  <= is_gate ? words[0] : '0;
            ctl_one_reg <= is_gate ? words[1] : '0;
            ctl_two_reg <= is_gate ? words[2] : '0;
        end
    end

`ifndef SYNTH
    a_wcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= 3'd4)
        else $error("word count out of range");

    a_comment_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_comment_reg && halted_reg))
        else $error("comment state while halted");

    a_gate_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_item.cls == CLS_SEMI && !halted_reg && !in_comment_reg
         && wcnt_reg == 3'd3)
        |=> out_valid_reg && kind_reg == KIND_GATE && wcnt_reg == 3'd0)
        else $error("closed gate not emitted");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_item.cls == CLS_END)
        |=> !halted_reg && wcnt_reg == 3'd0 && line_start_reg && tilde_reg == '0)
        else $error("end item did not reset parser");
`endif

endmodule

[design/gate_list_text_parser_top.sv]
// Top level of the gate-list text parser: front, queue and back stages.
// Path: a result passes the front register, a queue entry and the result register
// before it is valid, and the result register holds it while m_tready is low.
// Throughput: one character per cycle unless the output stalls; the back stage retires
// one queue entry per cycle and its result register refills in the cycle it is taken.
// Reset: rst_n clears all control state at once; parser starts at line start,
// not halted, no pending words. No clearing pass is needed.
module gate_list_text_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    // character stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_end: end of text, tdata ignored
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] target_wire, [31:16] control_one,
                                   // [47:32] control_two
    output logic [2:0]  m_tuser    // [2:0] result_kind
);
    import glp_pkg::*;

    // front -> queue
    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    // queue -> back
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    logic [KIND_W-1:0] kind;
    logic [WIRE_W-1:0] target;
    logic [WIRE_W-1:0] ctl_one;
    logic [WIRE_W-1:0] ctl_two;

    // Classify each character; no parser state lives here.
    glp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_char    (s_tdata),
        .in_end     (s_tlast),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item)
    );

    // Decouples front and back so each can stall on its own.
    glp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // Parser state machine, word assembly and result register.
    glp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (q_valid),
        .pop_ready   (q_ready),
        .pop_item    (q_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (kind),
        .out_target  (target),
        .out_ctl_one (ctl_one),
        .out_ctl_two (ctl_two)
    );

    assign m_tdata = {ctl_two, ctl_one, target};
    assign m_tuser = kind;

endmodule

[bench/tb_gate_list_text_parser_top.sv]
// Self-checking bench for the gate-list text parser: text stream in, gate reports out.
`timescale 1ns / 1ps

module tb_gate_list_text_parser_top;
    import glp_pkg::*;

    // Run limit in clock cycles; slowest legal run is far below this.
    localparam int CYCLE_LIMIT = 200000;
    // Receiver hold-off that backs the block up into s_tready.
    localparam int HOLD_CYCLES = 400;
    // Random text length, in characters plus end markers.
    localparam int RANDOM_CHARS = 1700;

    // One character transfer: tdata carries the byte, tlast the end-of-text flag.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_end;
    } text_item_t;

    // One result transfer as the bench expects it.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WIRE_W-1:0] target;
        logic [WIRE_W-1:0] ctl_one;
        logic [WIRE_W-1:0] ctl_two;
    } gate_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    gate_list_text_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Characters still to be offered, and reports still owed by the block.
    text_item_t   text_queue[$];
    gate_report_t expected_reports[$];

    int  chars_queued = 0;
    int  chars_sent   = 0;
    int  error_count  = 0;
    int  cycle_count  = 0;
    bit  hold_off     = 1'b0;

    string symbols =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()-_=+[]{}<>?";

    // ------------------------------------------------------------------
    // Parser prediction: own copy of the text state
    // ------------------------------------------------------------------
    bit                in_comment;
    bit                at_line_start;
    int unsigned       tilde_count;
    logic [WIRE_W-1:0] word_store[3];
    int unsigned       word_count;
    bit                halted;

    function automatic void clear_parser();
        in_comment    = 1'b0;
        at_line_start = 1'b1;
        tilde_count   = 0;
        word_count    = 0;
        halted        = 1'b0;
    endfunction

    // Alphabet position of a byte, -1 when it is no symbol.
    function automatic int symbol_pos(input logic [CHAR_W-1:0] ch);
        for (int i = 0; i < symbols.len(); i++)
        begin
            if (symbols[i] == ch)
                return i;
        end
        return -1;
    endfunction

    // Advances the parser by one item; returns 1 when a report comes out.
    function automatic bit parse_char(input text_item_t it, output gate_report_t rep);
        logic [CHAR_W-1:0] ch;
        bit                newline;
        bit                emit;
        int                sym;
        longint            value;
        ch      = it.char_code;
        newline = (ch == CH_LF) || (ch == CH_CR);
        emit    = 1'b0;
        rep     = '0;
        if (it.is_end)
        begin
            if (!halted)
            begin
                emit     = 1'b1;
                rep.kind = (word_count != 0) ? KIND_UNTERMINATED : KIND_END_OK;
            end
            clear_parser();
        end
        else if (!halted)
        begin
            if (in_comment)
            begin
                if (newline)
                begin
                    in_comment    = 1'b0;
                    at_line_start = 1'b1;
                end
            end
            else if (at_line_start && ch == CH_HASH)
            begin
                // comment keeps pending words and tildes
                in_comment = 1'b1;
            end
            else if (ch == CH_SEMI)
            begin
                tilde_count = 0;
                if (word_count == 3)
                begin
                    emit        = 1'b1;
                    rep.kind    = KIND_GATE;
                    rep.target  = word_store[0];
                    rep.ctl_one = word_store[1];
                    rep.ctl_two = word_store[2];
                    word_count  = 0;
                end
                else if (word_count != 0)
                begin
                    emit     = 1'b1;
                    rep.kind = KIND_BAD_COUNT;
                    halted   = 1'b1;
                end
            end
            else if (ch == CH_TILDE)
            begin
                at_line_start = 1'b0;
                if (tilde_count >= TILDE_MAX)
                begin
                    emit     = 1'b1;
                    rep.kind = KIND_OVERFLOW;
                    halted   = 1'b1;
                end
                else
                    tilde_count++;
            end
            else if (newline || ch == CH_TAB || ch == CH_SPACE)
            begin
                if (newline)
                    at_line_start = 1'b1;
            end
            else
            begin
                sym = symbol_pos(ch);
                value = longint'(sym) + longint'(ALPHA_BASE) * longint'(tilde_count);
                if (sym < 0)
                begin
                    emit     = 1'b1;
                    rep.kind = KIND_BAD_CHAR;
                    halted   = 1'b1;
                end
                else if (value >= (longint'(1) << INDEX_WIDTH))
                begin
                    emit     = 1'b1;
                    rep.kind = KIND_OVERFLOW;
                    halted   = 1'b1;
                end
                else
                begin
                    if (word_count < 3)
                        word_store[word_count] = value[WIRE_W-1:0];
                    if (word_count < 4)
                        word_count++;
                    tilde_count   = 0;
                    at_line_start = 1'b0;
                end
            end
        end
        return emit;
    endfunction

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------
    task automatic push_char(input logic [CHAR_W-1:0] ch);
        text_item_t it;
        it.char_code = ch;
        it.is_end    = 1'b0;
        text_queue.insert(text_queue.size(), it);
        chars_queued++;
    endtask

    // End marker; the byte beside it is don't-care, so it is random.
    task automatic push_end();
        text_item_t it;
        it.char_code = CHAR_W'($urandom_range(0, 255));
        it.is_end    = 1'b1;
        text_queue.insert(text_queue.size(), it);
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    task automatic push_tildes(input int n);
        for (int i = 0; i < n; i++)
            push_char(CH_TILDE);
    endtask

    task automatic push_line_end();
        case ($urandom_range(0, 3))
            0: push_char(CH_LF);
            1: push_char(CH_CR);
            2: push_text("\r\n");
            default: push_text(" \n");
        endcase
    endtask

    // Full comment line: newline, '#', body without line breaks, newline.
    task automatic push_comment();
        logic [CHAR_W-1:0] ch;
        push_line_end();
        push_char(CH_HASH);
        repeat ($urandom_range(0, 8))
        begin
            ch = CHAR_W'($urandom_range(0, 255));
            push_char((ch == CH_LF || ch == CH_CR) ? CH_SPACE : ch);
        end
        push_line_end();
    endtask

    // Mostly plain words, a few with a long tilde prefix.
    function automatic int draw_tildes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic push_word();
        push_tildes(draw_tildes());
        // blanks between tildes and symbol do not break the word
        if ($urandom_range(0, 19) == 0)
            push_char(CH_SPACE);
        push_char(symbols[$urandom_range(0, 82)]);
    endtask

    task automatic push_separator();
        if ($urandom_range(0, 11) == 0)
            push_comment();
        else
            repeat ($urandom_range(1, 2))
                push_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic push_gate(input int words, input bit closed);
        for (int w = 0; w < words; w++)
        begin
            push_word();
            if (w + 1 < words || $urandom_range(0, 3) == 0)
                push_separator();
        end
        if (closed)
            push_char(CH_SEMI);
    endtask

    // One text up to its end marker; mostly well-formed gate lines.
    task automatic push_document();
        int pick;
        int count_pick;
        repeat ($urandom_range(1, 6))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
                push_gate(3, 1'b1);
            else if (pick < 72)
                push_comment();
            else if (pick < 77)
                push_char(CH_SEMI);
            else if (pick < 84)
            begin
                count_pick = $urandom_range(0, 3);
                push_gate((count_pick < 2) ? count_pick + 1 : count_pick + 2, 1'b1);
            end
            else if (pick < 90)
                push_char(CHAR_W'($urandom_range(0, 255)));
            else
                repeat ($urandom_range(1, 6))
                    push_char(CHAR_W'($urandom_range(0, 255)));
            push_line_end();
        end
        pick = $urandom_range(0, 19);
        if (pick < 2)
            push_gate($urandom_range(1, 3), 1'b0);
        else if (pick == 2)
            push_tildes($urandom_range(1, 4));
        push_end();
    endtask

    task automatic wait_drained();
        while (text_queue.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sender: offers queued characters, random gaps between transfers
    // ------------------------------------------------------------------
    text_item_t cur_char;
    int         send_wait    = 0;
    bit         sender_burst = 1'b0;

    always @(posedge clk)
    begin : text_driver
        gate_report_t rep;
        bit           offering;
        if (rst_n)
        begin
            offering = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                if (parse_char(cur_char, rep))
                    expected_reports.insert(expected_reports.size(), rep);
                chars_sent++;
                offering = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    sender_burst = !sender_burst;
                send_wait = sender_burst ? 0 : $urandom_range(0, 5);
            end
            if (!offering)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (text_queue.size() != 0)
                begin
                    cur_char = text_queue.pop_front();
                    s_tdata  <= cur_char.char_code;
                    s_tlast  <= cur_char.is_end;
                    offering = 1'b1;
                end
            end
            // single update per edge keeps back-to-back valid glitch-free
            s_tvalid <= offering;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: takes reports with random stalls and checks each field
    // ------------------------------------------------------------------
    int recv_wait      = 0;
    bit receiver_burst = 1'b0;

    always @(posedge clk)
    begin : report_monitor
        gate_report_t want;
        bit           take;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report with none expected: kind %0d, data %h", m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[15:0] !== want.target)
                    begin
                        $error("target_wire: expected %0d, got %0d",
                               want.target, m_tdata[15:0]);
                        error_count++;
                    end
                    if (m_tdata[31:16] !== want.ctl_one)
                    begin
                        $error("control_one: expected %0d, got %0d",
                               want.ctl_one, m_tdata[31:16]);
                        error_count++;
                    end
                    if (m_tdata[47:32] !== want.ctl_two)
                    begin
                        $error("control_two: expected %0d, got %0d",
                               want.ctl_two, m_tdata[47:32]);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 29) == 0)
                    receiver_burst = !receiver_burst;
                recv_wait = receiver_burst ? 0 : $urandom_range(0, 5);
            end
            if (hold_off)
                take = 1'b0;
            else if (recv_wait > 0)
            begin
                recv_wait--;
                take = 1'b0;
            end
            else
                take = 1'b1;
            m_tready <= take;
        end
    end

    // Long receiver hold-off once the random text is flowing.
    initial
    begin
        wait (chars_sent >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_parser();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // extreme symbols '0', '?' and the first tilde step
        push_text("0 ?\t~0;");
        // comment at line start, then '#' inside a line is a symbol
        push_text("\n#x\r");
        push_text("a#Z;");
        // empty gate, then a clean end
        push_char(CH_SEMI);
        push_end();
        // pending word at end
        push_char("b");
        push_end();
        // one word before ';', halted char ignored, silent end
        push_text("c;d");
        push_end();
        // bad character, silent end, then a clean end
        push_char(".");
        push_end();
        push_end();

        // sender pauses until every report is back
        wait_drained();

        while (chars_queued < RANDOM_CHARS)
            push_document();

        // largest index 65535, then the first value past the index range
        push_tildes(789);
        push_text("M ? 0;\n");
        push_tildes(789);
        push_char("N");
        push_end();
        // tilde count running past its limit
        push_tildes(1024);
        push_end();
        // a few more ordinary texts after the long runs
        repeat (4)
            push_document();

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_reports.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
design/glp_pkg.sv
design/glp_front.sv
design/glp_queue.sv
design/glp_back.sv
design/gate_list_text_parser_top.sv
bench/tb_gate_list_text_parser_top.sv
